>>> rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the descending selection sorter.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int VAL_W   = 32;  // 16.16 unsigned fixed point
  localparam int Q_DEPTH = 4;   // front-to-back queue entries
  localparam int Q_AW    = 2;   // queue pointer width
  localparam int Q_CW    = 3;   // queue fill width (holds Q_DEPTH)

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             keep;       // fits in the store
    logic             dropped;    // set has lost at least one value so far
    logic             last_item;  // closes the set
  } q_entry_t;

endpackage

>>> rtl/sds_ram.sv
// ----------------------------------------------------------------------------
// sds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sds_fifo.sv
// ----------------------------------------------------------------------------
// sds_fifo
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module sds_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sds_pkg::q_entry_t din,
  input  logic              pop,
  output sds_pkg::q_entry_t dout,
  output logic              empty,
  output logic              full
);

  sds_pkg::q_entry_t               slot_r [sds_pkg::Q_DEPTH];
  logic [sds_pkg::Q_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [sds_pkg::Q_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [sds_pkg::Q_CW-1:0]        fill_r, fill_nxt;

  assign empty = (fill_r == '0);
  assign full  = (fill_r == sds_pkg::Q_CW'(sds_pkg::Q_DEPTH));
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  // Writer must never push into a full queue unless it drains in the same cycle.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("sds_fifo: push while full");

endmodule

>>> rtl/sds_front.sv
// ----------------------------------------------------------------------------
// sds_front
// Input side: takes items, counts the set and marks values that overflow.
// ----------------------------------------------------------------------------
module sds_front #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sds_pkg::VAL_W-1:0]   in_sample_value,
  input  logic                        in_final_item,
  output logic                        q_push,
  output sds_pkg::q_entry_t           q_entry,
  input  logic                        q_full
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          keep;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = (count_r < CW'(MAX_ITEMS));

  assign q_entry.value     = in_sample_value;
  assign q_entry.keep      = keep;
  assign q_entry.dropped   = ovf_r || !keep;
  assign q_entry.last_item = in_final_item;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (q_push) begin
      if (in_final_item) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        if (keep) begin
          count_nxt = count_r + 1'b1;
        end
        ovf_nxt = ovf_r || !keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> rtl/sds_back.sv
// ----------------------------------------------------------------------------
// sds_back
// Store, selection sort over the value RAM, and registered result output.
// ----------------------------------------------------------------------------
module sds_back #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sds_pkg::q_entry_t           q_entry,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sds_pkg::VAL_W-1:0]   out_sorted_value,
  output logic                        out_end_of_run,
  output logic                        out_items_dropped
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_PRIME = 7'b0000010,
    S_PVAL  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SWAP1 = 7'b0010000,
    S_SWAP2 = 7'b0100000,
    S_ORD   = 7'b1000000
  } state_t;

  // S_ORD doubles as the wait state: a flag tells whether read data is ready.
  state_t                     state_r, state_nxt;
  logic [CW-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]              n_r, n_nxt;
  logic                       run_drop_r, run_drop_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [AW-1:0]              k_r, k_nxt;
  logic [AW-1:0]              best_r, best_nxt;
  logic [AW-1:0]              oidx_r, oidx_nxt;
  logic                       ord_rdy_r, ord_rdy_nxt;
  logic [sds_pkg::VAL_W-1:0]  best_val_r, best_val_nxt;
  logic [sds_pkg::VAL_W-1:0]  pos_val_r, pos_val_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [sds_pkg::VAL_W-1:0]  out_value_r, out_value_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_drop_r, out_drop_nxt;
  logic                       out_free;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [sds_pkg::VAL_W-1:0]  ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [sds_pkg::VAL_W-1:0]  ram_rdata;
  logic [CW-1:0]              n_at_close;

  sds_ram #(
    .WIDTH (sds_pkg::VAL_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_pop      = (state_r == S_LOAD) && !q_empty;
  assign out_free   = !out_valid_r || !out_stall;
  assign n_at_close = q_entry.keep ? (wr_ptr_r + 1'b1) : wr_ptr_r;

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    n_nxt         = n_r;
    run_drop_nxt  = run_drop_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    oidx_nxt      = oidx_r;
    ord_rdy_nxt   = 1'b0;
    best_val_nxt  = best_val_r;
    pos_val_nxt   = pos_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_ptr_r[AW-1:0];
    ram_wdata     = q_entry.value;
    ram_raddr     = oidx_r;

    case (state_r)
      S_LOAD: begin
        if (q_pop) begin
          if (q_entry.keep) begin
            ram_we     = 1'b1;
            wr_ptr_nxt = wr_ptr_r + 1'b1;
          end
          if (q_entry.last_item) begin
            n_nxt        = n_at_close;
            run_drop_nxt = q_entry.dropped;
            wr_ptr_nxt   = '0;
            pos_nxt      = '0;
            oidx_nxt     = '0;
            state_nxt    = (n_at_close >= CW'(2)) ? S_PRIME : S_ORD;
          end
        end
      end
      S_PRIME: begin
        ram_raddr = pos_r;
        state_nxt = S_PVAL;
      end
      S_PVAL: begin
        best_val_nxt = ram_rdata;
        pos_val_nxt  = ram_rdata;
        best_nxt     = pos_r;
        ram_raddr    = pos_r + 1'b1;
        k_nxt        = pos_r + 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // ram_rdata holds entry k_r; strictly greater wins, so the earliest of equal values is chosen
        if (ram_rdata > best_val_r) begin
          best_val_nxt = ram_rdata;
          best_nxt     = k_r;
        end
        ram_raddr = k_r + 1'b1;
        if (({1'b0, k_r} + CW'(1)) == n_r) begin
          state_nxt = S_SWAP1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_SWAP1: begin
        ram_we    = 1'b1;
        ram_waddr = best_r;
        ram_wdata = pos_val_r;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = best_val_r;
        if (({1'b0, pos_r} + CW'(2)) >= n_r) begin
          oidx_nxt  = '0;
          state_nxt = S_ORD;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_PRIME;
        end
      end
      S_ORD: begin
        ram_raddr = oidx_r;
        if (!ord_rdy_r) begin
          ord_rdy_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = ram_rdata;
          out_drop_nxt  = run_drop_r;
          out_last_nxt  = (({1'b0, oidx_r} + CW'(1)) == n_r);
          if (({1'b0, oidx_r} + CW'(1)) == n_r) begin
            state_nxt = S_LOAD;
          end else begin
            oidx_nxt = oidx_r + 1'b1;
          end
        end else begin
          ord_rdy_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      wr_ptr_r    <= '0;
      ord_rdy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      ord_rdy_r   <= ord_rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    run_drop_r  <= run_drop_nxt;
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    best_r      <= best_nxt;
    oidx_r      <= oidx_nxt;
    best_val_r  <= best_val_nxt;
    pos_val_r   <= pos_val_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_value  = out_value_r;
  assign out_end_of_run    = out_last_r;
  assign out_items_dropped = out_drop_r;

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r > pos_r && {1'b0, k_r} < n_r))
    else $error("sds_back: scan index out of range");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (best_r >= pos_r && best_r < k_r))
    else $error("sds_back: best index outside scanned window");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= CW'(MAX_ITEMS))
    else $error("sds_back: store fill beyond capacity");

endmodule

>>> rtl/selection_sort_descending_unit.sv
// ----------------------------------------------------------------------------
// selection_sort_descending_unit
// Collects a set of 16.16 values, sorts it in descending order by selection
// sort and streams the sorted set out with an end mark and an overflow flag.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  -----------------------------------
//  in_      in         in_valid/in_stall  sample_value[31:0], final_item
//  out_     out        out_valid/out_stall sorted_value[31:0], end_of_run,
//                                          items_dropped
//
//  Steps: loading takes one value per cycle from the queue while it is not
//    empty. Each sort position is fetched (S_PRIME, S_PVAL), compared with
//    each later entry (S_SCAN) and swapped (S_SWAP1, S_SWAP2); each result is
//    read in S_ORD, all through the single read port of the value RAM.
//  Reset: rst_n is synchronous, active low; it empties the queue and the set.
//  Stalls: a four-entry queue takes up to four input transfers while the
//    back end sorts or waits on out_stall, then in_stall holds the input;
//    the output register holds a result until its transfer.
//
module selection_sort_descending_unit #(
  parameter int MAX_ITEMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_value,
  input  logic        in_final_item,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sorted_value,
  output logic        out_end_of_run,
  output logic        out_items_dropped
);

  // front -> queue
  logic              q_push;
  sds_pkg::q_entry_t q_din;
  logic              q_full;
  // queue -> back
  logic              q_pop;
  sds_pkg::q_entry_t q_dout;
  logic              q_empty;

  // Front: counts the set and tags each value kept or dropped.
  sds_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_final_item   (in_final_item),
    .q_push          (q_push),
    .q_entry         (q_din),
    .q_full          (q_full)
  );

  // Queue decouples the input transfer from the sort.
  sds_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back: stores values, sorts in place, drives the result register.
  sds_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_entry           (q_dout),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_end_of_run    (out_end_of_run),
    .out_items_dropped (out_items_dropped)
  );

endmodule

>>> tb/sds_sort_checker.sv
// ----------------------------------------------------------------------------
// sds_sort_checker
// Watches both channels of the descending sorter, keeps its own copy of the
// set being collected, predicts each sorted set when it closes and compares
// every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module sds_sort_checker #(
  parameter int MAX_ITEMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_sample_value,
  input  logic        in_final_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_sorted_value,
  input  logic        out_end_of_run,
  input  logic        out_items_dropped,
  output int          mismatch_count,
  output int          outstanding,
  output int          results_checked,
  output int          sets_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic        end_of_run;
    logic        dropped;
  } sorted_result_t;

  logic [31:0]    set_vals [MAX_ITEMS];
  int             set_len;
  logic           set_overflow;
  sorted_result_t expected_sorted [$];

  // Selection sort, strictly greater wins, so the earliest of equal values is picked.
  function automatic void sort_set_descending();
    int          best;
    logic [31:0] best_val;
    for (int pos = 0; pos + 1 < set_len; pos++) begin
      best     = pos;
      best_val = set_vals[pos];
      for (int k = pos + 1; k < set_len; k++) begin
        if (set_vals[k] > best_val) begin
          best_val = set_vals[k];
          best     = k;
        end
      end
      set_vals[best] = set_vals[pos];
      set_vals[pos]  = best_val;
    end
  endfunction

  always @(posedge clk) begin
    sorted_result_t exp_r;
    if (!rst_n) begin
      set_len      = 0;
      set_overflow = 1'b0;
      expected_sorted.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (set_len < MAX_ITEMS) begin
          set_vals[set_len] = in_sample_value;
          set_len++;
        end else begin
          set_overflow = 1'b1;
        end
        if (in_final_item) begin
          sort_set_descending();
          for (int k = 0; k < set_len; k++) begin
            exp_r.value      = set_vals[k];
            exp_r.end_of_run = (k == set_len - 1);
            exp_r.dropped    = set_overflow;
            expected_sorted.push_back(exp_r);
          end
          sets_closed++;
          set_len      = 0;
          set_overflow = 1'b0;
        end
      end

      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_sorted.size() == 0) begin
          mismatch_count++;
          $error("unexpected result transfer: sorted_value %h", out_sorted_value);
        end else begin
          exp_r = expected_sorted.pop_front();
          if (out_sorted_value !== exp_r.value) begin
            mismatch_count++;
            $error("sorted_value: expected %h, actual %h", exp_r.value, out_sorted_value);
          end
          if (out_end_of_run !== exp_r.end_of_run) begin
            mismatch_count++;
            $error("end_of_run: expected %b, actual %b", exp_r.end_of_run, out_end_of_run);
          end
          if (out_items_dropped !== exp_r.dropped) begin
            mismatch_count++;
            $error("items_dropped: expected %b, actual %b", exp_r.dropped,
                   out_items_dropped);
          end
        end
      end
    end
    outstanding <= expected_sorted.size();
  end

endmodule

>>> tb/selection_sort_descending_unit_tb.sv
// ----------------------------------------------------------------------------
// selection_sort_descending_unit_tb
// Feeds sets of 16.16 values into the descending sorter: a directed opening
// (single-value sets, extremes, duplicates, a set past capacity) and then
// random sets of every size up to a few past capacity, under three idle
// profiles. A checker beside the block predicts and compares all results.
// ----------------------------------------------------------------------------
module selection_sort_descending_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP       = 16;       // store depth given to the block
  localparam int RANDOM_ITEMS  = 400;      // random items over all phases
  localparam int CYCLE_LIMIT   = 300000;   // far above the slowest clean run
  localparam int DRAIN_CYCLES  = 64;       // quiet time after the last result

  // value flavors for random sets
  typedef enum int {
    VAL_FULL,     // any 32-bit pattern
    VAL_NARROW,   // few distinct values, lots of ties
    VAL_CORNER,   // extremes only
    VAL_MIXED     // flavor chosen per value
  } value_flavor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_sample_value = '0;
  logic        in_final_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sorted_value;
  logic        out_end_of_run;
  logic        out_items_dropped;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int sets_closed;

  int send_idle_pct = 0;   // chance of an idle cycle on the input side
  int recv_stall_pct = 0;  // chance of stall on any cycle
  int items_sent = 0;
  int overflow_sets = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  selection_sort_descending_unit #(
    .MAX_ITEMS(SET_CAP)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_final_item    (in_final_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_run   (out_end_of_run),
    .out_items_dropped(out_items_dropped)
  );

  sds_sort_checker #(
    .MAX_ITEMS(SET_CAP)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_final_item    (in_final_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_run   (out_end_of_run),
    .out_items_dropped(out_items_dropped),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .sets_closed      (sets_closed)
  );

  // Receiver back-pressure, redrawn every cycle from the current profile.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(value_flavor_t flavor);
    value_flavor_t f;
    f = flavor;
    if (f == VAL_MIXED) begin
      f = value_flavor_t'($urandom_range(2));
    end
    case (f)
      VAL_NARROW: begin
        // a handful of integers and halves, so ties are common
        return {13'd0, 3'($urandom_range(7)), 1'($urandom_range(1)), 15'd0};
      end
      VAL_CORNER: begin
        case ($urandom_range(4))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          3:       return 32'h7FFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // One transfer on the input channel. Each idle cycle, when drawn, drops
  // valid and scrambles the payload, which the block must ignore.
  task automatic send_item(input logic [31:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid        <= 1'b0;
      in_sample_value <= $urandom;
      in_final_item   <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_final_item   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set(input int count, input value_flavor_t flavor);
    if (count > SET_CAP) overflow_sets++;
    for (int k = 0; k < count; k++) begin
      send_item(pick_value(flavor), k == count - 1);
    end
  endtask

  // Random sets: mostly mid sizes, with single values, full sets and sets
  // that run a few past capacity mixed in.
  task automatic run_random_sets(input int item_budget);
    int            start;
    int            count;
    int            pick;
    value_flavor_t flavor;
    start = items_sent;
    while (items_sent - start < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        count = 1;
      end else if (pick < 22) begin
        count = SET_CAP;
      end else if (pick < 34) begin
        count = SET_CAP + $urandom_range(1, 4);
      end else begin
        count = $urandom_range(2, SET_CAP - 1);
      end
      flavor = value_flavor_t'($urandom_range(3));
      send_set(count, flavor);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles lightly, receiver stalls half the time
    send_idle_pct  = 22;
    recv_stall_pct = 51;

    // single-value sets at both ends of the range
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    // extremes, ties and an out-of-order mix in one set
    send_item(32'h0001_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0001_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    // one past capacity: the closing value itself is discarded
    overflow_sets++;
    for (int k = 0; k < SET_CAP; k++) begin
      send_item(32'h0000_1000 * (k + 1), 1'b0);
    end
    send_item(32'hFFFF_FFFF, 1'b1);

    run_random_sets(RANDOM_ITEMS / 3);

    // phase 2: sender idles often, receiver stalls lightly
    send_idle_pct  = 51;
    recv_stall_pct = 22;
    run_random_sets(RANDOM_ITEMS / 3);

    // phase 3: full rate both ways
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_sets(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d value transfers in %0d sets (%0d past capacity),",
             items_sent, sets_closed, overflow_sets);
    $display("%0d sorted results checked under three idle/stall profiles",
             results_checked);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
